@@ src/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the rotate helper for the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [1:0] {
    CMD_ABSORB     = 2'd0,
    CMD_ABSORB_FIN = 2'd1,
    CMD_FINISH     = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  // Datapath byte source select
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } src_e;

  typedef struct packed {
    logic       push;       // write one byte into block store
    src_e       src;
    logic [2:0] len_idx;    // length byte, 0 = most significant
    logic       count;      // increment byte count
    logic       rnd_start;  // load working vars, clear round count
    logic       rnd_step;   // one round
    logic       rnd_fold;   // add working vars into chain
    logic       out_load;   // latch chain into output buffer
    logic       reinit;     // chain, count, fill back to initial
  } ctl_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] rnd;
  } sts_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_RND = 6'd63;

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/sha256_hash_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 with command-driven finish and eight-word digest output.
// ----------------------------------------------------------------------------
// One command transfer per cycle is taken while a block fills. The transfer
// that completes a 64-byte block also loads the working variables and is
// followed by 64 rounds, one per cycle, then the fold into the chain value,
// with input held off throughout. A finish pushes padding and the length one
// byte per cycle until the block is full (up to 64 bytes, and when the length
// does not fit, one compression and a further block of padding and length),
// then after the last compression latches the digest and presents the eight
// digest words, one per output transfer, before the next command is taken.
module sha256_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  ctl_t        ctl;
  sts_t        sts;
  logic [2:0]  idx;
  logic [31:0] word;
  cmd_e        cmd;

  assign cmd = cmd_e'(s_axis_tuser);

  sha256_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (cmd),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_idx_o  (idx)
  );

  sha256_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .data_byte_i  (s_axis_tdata),
    .out_idx_i    (idx),
    .digest_word_o(word)
  );

  assign m_axis_tdata = {5'd0, idx, word};
  assign m_axis_tlast = (idx == 3'd7);

endmodule

@@ src/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorb, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sha256_pkg::cmd_e     cmd_i,
  input  sha256_pkg::sts_t     sts_i,
  output sha256_pkg::ctl_t     ctl_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           out_idx_o
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic       fin_q, fin_d;     // finish pending after block
  logic       padded_q, padded_d;
  logic [2:0] len_q, len_d;
  logic [2:0] oidx_q, oidx_d;
  logic       acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  // first cycle of ST_OUT latches the digest, no transfer yet
  assign out_valid_o = (state_q == ST_OUT) && (len_q != 3'd7);
  assign out_idx_o   = oidx_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    fin_d    = fin_q;
    padded_d = padded_q;
    len_d    = len_q;
    oidx_d   = oidx_q;
    ctl_o    = '0;
    ctl_o.src = SRC_DATA;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (cmd_i)
            CMD_ABSORB, CMD_ABSORB_FIN: begin
              ctl_o.push  = 1'b1;
              ctl_o.count = 1'b1;
              fin_d       = (cmd_i == CMD_ABSORB_FIN);
              padded_d    = 1'b0;
              if (sts_i.fill == LAST_RND) begin
                ctl_o.rnd_start = 1'b1;
                state_d = ST_ROUND;
              end else if (cmd_i == CMD_ABSORB_FIN) begin
                state_d = ST_PAD;
              end
            end
            CMD_FINISH: begin
              fin_d    = 1'b1;
              padded_d = 1'b0;
              state_d  = ST_PAD;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        ctl_o.push = 1'b1;
        ctl_o.src  = padded_q ? SRC_ZERO : SRC_PAD;
        padded_d   = 1'b1;
        len_d      = '0;
        if (sts_i.fill == LAST_RND) begin
          ctl_o.rnd_start = 1'b1;
          state_d = ST_ROUND;
        end else if (sts_i.fill == LEN_POS - 6'd1) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        ctl_o.push    = 1'b1;
        ctl_o.src     = SRC_LEN;
        ctl_o.len_idx = len_q;
        len_d         = len_q + 3'd1;
        if (sts_i.fill == LAST_RND) begin
          ctl_o.rnd_start = 1'b1;
          fin_d   = 1'b1;
          padded_d = 1'b1;
          len_d   = 3'd7;  // marks length written
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl_o.rnd_step = 1'b1;
        if (sts_i.rnd == LAST_RND) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        ctl_o.rnd_fold = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (padded_q && len_q == 3'd7) begin
          state_d = ST_OUT;
          oidx_d  = '0;
        end else begin
          padded_d = padded_q;
          state_d  = ST_PAD;
        end
      end
      ST_OUT: begin
        if (len_q == 3'd7) begin
          ctl_o.out_load = 1'b1;
          ctl_o.reinit   = 1'b1;
          len_d          = '0;
        end else if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d = ST_IDLE;
            fin_d   = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fin_q    <= 1'b0;
      padded_q <= 1'b0;
      len_q    <= '0;
      oidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      fin_q    <= fin_d;
      padded_q <= padded_d;
      len_q    <= len_d;
      oidx_q   <= oidx_d;
    end
  end

endmodule

@@ src/sha256_dp.sv @@
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block store, byte count, message schedule, round unit and chain value.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha256_pkg::ctl_t ctl_i,
  output sha256_pkg::sts_t sts_o,
  input  logic [7:0]       data_byte_i,
  input  logic [2:0]       out_idx_i,
  output logic [31:0]      digest_word_o
);
  import sha256_pkg::*;

  logic [5:0]  fill_q;
  logic [63:0] cnt_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] dig_q [8];
  logic [5:0]  rnd_q;
  logic [7:0]  byte_d;
  logic [63:0] bits;
  logic [31:0] s0, s1, wn, t1, t2, e, a, wcur;

  assign bits = {cnt_q[60:0], 3'b000};
  assign sts_o.fill = fill_q;
  assign sts_o.rnd  = rnd_q;
  assign digest_word_o = dig_q[out_idx_i];

  always_comb begin
    case (ctl_i.src)
      SRC_DATA: byte_d = data_byte_i;
      SRC_PAD:  byte_d = PAD_BYTE;
      SRC_ZERO: byte_d = 8'h00;
      SRC_LEN:  byte_d = bits[8*(7-ctl_i.len_idx) +: 8];
      default:  byte_d = 8'h00;
    endcase
  end

  // w_q holds the block as it fills (big-endian words), then serves as the
  // schedule window: w_q[0] is the current round word, shifted each round
  assign wcur = w_q[0];
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wn = s1 + w_q[9] + s0 + w_q[0];
  assign e  = v_q[4];
  assign a  = v_q[0];
  assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[rnd_q] + wcur;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= byte_d;
    if (ctl_i.rnd_start) begin
      for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
    end else if (ctl_i.rnd_step) begin
      for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
      w_q[15] <= wn;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (ctl_i.out_load) begin
      for (int j = 0; j < 8; j++) dig_q[j] <= h_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      rnd_q  <= '0;
      for (int j = 0; j < 8; j++) h_q[j] <= H_INIT[j];
    end else begin
      if (ctl_i.push)  fill_q <= fill_q + 6'd1;
      if (ctl_i.count) cnt_q  <= cnt_q + 64'd1;
      if (ctl_i.rnd_start)     rnd_q <= '0;
      else if (ctl_i.rnd_step) rnd_q <= rnd_q + 6'd1;
      if (ctl_i.rnd_fold) begin
        for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
      end
      if (ctl_i.reinit) begin
        fill_q <= '0;
        cnt_q  <= '0;
        for (int j = 0; j < 8; j++) h_q[j] <= H_INIT[j];
      end
    end
  end

endmodule

@@ src/sha256_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level assertions, bound to the hash engine.
// ----------------------------------------------------------------------------
module sha256_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast mismatch");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
    m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    else $error("word index skip");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output not held");
endmodule

bind sha256_hash_engine sha256_props u_chk (.*);
